/* hdl/lot_sizing_dp_top_defines.svh */
// assertion macros for the lot sizing block
// needs clk and rst in the scope of the module that uses them
`ifndef LOT_SIZING_DP_TOP_DEFINES_SVH
`define LOT_SIZING_DP_TOP_DEFINES_SVH

`ifndef SYNTHESIS
`define LSDP_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`define LSDP_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define LSDP_ASSERT_IMP(lbl, ante, cons, msg)
`define LSDP_ASSERT_NXT(lbl, ante, cons, msg)
`endif

`endif

/* hdl/lsdp_pkg.sv */
// types, widths and sequencer states for the lot sizing block
// no dependencies
package lsdp_pkg;

  localparam int DEM_W   = 16;
  localparam int UCOST_W = 16;
  localparam int SETUP_W = 24;
  localparam int HOLD_W  = 16;
  localparam int IDX_W   = 6;
  localparam int QTY_W   = 22;
  localparam int COST_W  = 48;
  localparam int CARRY_W = 24;
  localparam int OPND_W  = 25;
  localparam int PROD_W  = 41;
  localparam int INIT_W  = 32;

  typedef struct packed {
    logic [DEM_W-1:0]   demand;
    logic [UCOST_W-1:0] unit_cost;
    logic [SETUP_W-1:0] setup_cost;
    logic [HOLD_W-1:0]  holding_cost;
    logic               last_period;
  } item_t;

  typedef struct packed {
    logic [IDX_W-1:0]  period_index;
    logic [QTY_W-1:0]  lot_quantity;
    logic [COST_W-1:0] total_cost;
    logic              last_result;
  } result_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_KRD,
    ST_KLD,
    ST_JRD,
    ST_JCARRY,
    ST_JMUL,
    ST_JLOT,
    ST_JCMP,
    ST_KEND,
    ST_BRD,
    ST_BSEL,
    ST_DRD,
    ST_DACC,
    ST_ERD,
    ST_ELOAD
  } state_t;

endpackage

/* hdl/lot_sizing_dp_top.sv */
// lot sizing (wagner-whitin) over up to MAX_PERIODS periods; uses lsdp_pkg and the defines header
// an ordinary period is stored on acceptance while the sequencer is idle; the horizon-ending transfer starts the solve
// solve: per period k, each candidate j <= k steps through JRD, JCARRY, JMUL, JLOT, JCMP on the shared mac unit
// backtrack: BRD, BSEL, then DRD/DACC per period of each lot; then results go out through ERD, ELOAD when not stalled
// synchronous reset clears the sequencer, the period count and result_valid
`include "lot_sizing_dp_top_defines.svh"

module lot_sizing_dp_top #(
  parameter int MAX_PERIODS = 32
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            item_valid,
  output logic            item_stall,
  input  lsdp_pkg::item_t item,
  output logic            result_valid,
  input  logic            result_stall,
  output lsdp_pkg::result_t result
);
  import lsdp_pkg::*;

  localparam int AW = $clog2(MAX_PERIODS);
  localparam int CW = $clog2(MAX_PERIODS + 1);

  state_t state, state_next;

  logic [CW-1:0] count;
  logic [AW-1:0] k, j, last_idx, bk, bj, seg_s, ei, arg;
  logic [DEM_W-1:0]  dem_k;
  logic [HOLD_W-1:0] hold_k;
  logic [OPND_W-1:0] opnd;
  logic [PROD_W-1:0] prod;
  logic [COST_W-1:0] lot_hold, bprev, best_r, total;
  logic [QTY_W-1:0]  acc;
  logic [MAX_PERIODS-1:0] setup_flag;

  logic accept, full, store, start, out_free, result_load;
  logic carry_we, lot_we, best_we, qty_we;
  logic [AW-1:0] store_idx, dem_ra, hold_ra, best_ra, seg_sel;
  logic [INIT_W-1:0]  init_prod;
  logic [COST_W-1:0]  lot_init, lot_new, cand;
  logic [CARRY_W-1:0] carry_new;
  logic [QTY_W-1:0]   acc_new;

  // memory read data
  logic [DEM_W-1:0]   dem_q;
  logic [UCOST_W-1:0] unit_q;
  logic [HOLD_W-1:0]  hold_q;
  logic [CARRY_W-1:0] carry_q;
  logic [COST_W-1:0]  lot_q, best_q;
  logic [AW-1:0]      setup_q;
  logic [QTY_W-1:0]   qty_q;

  logic [DEM_W-1:0]   dem_mem   [MAX_PERIODS];
  logic [UCOST_W-1:0] unit_mem  [MAX_PERIODS];
  logic [HOLD_W-1:0]  hold_mem  [MAX_PERIODS];
  logic [CARRY_W-1:0] carry_mem [MAX_PERIODS];
  logic [COST_W-1:0]  lot_mem   [MAX_PERIODS];
  logic [COST_W-1:0]  best_mem  [MAX_PERIODS];
  logic [AW-1:0]      setup_mem [MAX_PERIODS];
  logic [QTY_W-1:0]   qty_mem   [MAX_PERIODS];

  assign accept    = item_valid && !item_stall;
  assign full      = (count == CW'(MAX_PERIODS));
  assign store     = accept && !full;
  assign start     = accept && (full || item.last_period);
  assign store_idx = count[AW-1:0];
  assign out_free  = !result_valid || !result_stall;

  assign init_prod = INIT_W'(item.unit_cost) * INIT_W'(item.demand);
  assign lot_init  = COST_W'(item.setup_cost) + COST_W'(init_prod);
  assign carry_new = carry_q + CARRY_W'(hold_k);
  assign lot_new   = lot_hold + ((j != k) ? COST_W'(prod) : '0);
  assign cand      = lot_hold + bprev;
  assign acc_new   = acc + QTY_W'(dem_q);
  assign seg_sel   = (setup_q > bk) ? bk : setup_q;

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:   if (start) state_next = ST_KRD;
      ST_KRD:    state_next = ST_KLD;
      ST_KLD:    state_next = ST_JRD;
      ST_JRD:    state_next = ST_JCARRY;
      ST_JCARRY: state_next = ST_JMUL;
      ST_JMUL:   state_next = ST_JLOT;
      ST_JLOT:   state_next = ST_JCMP;
      ST_JCMP:   state_next = (j == k) ? ST_KEND : ST_JRD;
      ST_KEND:   state_next = (k == last_idx) ? ST_BRD : ST_KRD;
      ST_BRD:    state_next = ST_BSEL;
      ST_BSEL:   state_next = ST_DRD;
      ST_DRD:    state_next = ST_DACC;
      ST_DACC: begin
        if (bj == bk) state_next = (seg_s == '0) ? ST_ERD : ST_BRD;
        else          state_next = ST_DRD;
      end
      ST_ERD:    state_next = ST_ELOAD;
      ST_ELOAD: begin
        if (out_free) state_next = (ei == last_idx) ? ST_IDLE : ST_ERD;
      end
      default:   state_next = ST_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    item_stall  = 1'b1;
    carry_we    = 1'b0;
    lot_we      = 1'b0;
    best_we     = 1'b0;
    qty_we      = 1'b0;
    result_load = 1'b0;
    dem_ra      = k;
    case (state)
      ST_IDLE:   item_stall = rst;
      ST_JCARRY: carry_we = (j != k);
      ST_JLOT:   lot_we = (j != k);
      ST_KEND:   best_we = 1'b1;
      ST_DRD:    dem_ra = bj;
      ST_DACC:   qty_we = (bj == bk);
      ST_ELOAD:  result_load = out_free;
      default:   item_stall = 1'b1;
    endcase
  end

  assign hold_ra = k - AW'(1);
  assign best_ra = j - AW'(1);

  // period stores
  always_ff @(posedge clk) begin
    if (store) begin
      dem_mem[store_idx]  <= item.demand;
      unit_mem[store_idx] <= item.unit_cost;
      hold_mem[store_idx] <= item.holding_cost;
    end
    dem_q  <= dem_mem[dem_ra];
    unit_q <= unit_mem[j];
    hold_q <= hold_mem[hold_ra];
  end

  always_ff @(posedge clk) begin
    if (store) carry_mem[store_idx] <= '0;
    else if (carry_we) carry_mem[j] <= carry_new;
    carry_q <= carry_mem[j];
  end

  always_ff @(posedge clk) begin
    if (store) lot_mem[store_idx] <= lot_init;
    else if (lot_we) lot_mem[j] <= lot_new;
    lot_q <= lot_mem[j];
  end

  always_ff @(posedge clk) begin
    if (best_we) begin
      best_mem[k]  <= best_r;
      setup_mem[k] <= arg;
    end
    best_q  <= best_mem[best_ra];
    setup_q <= setup_mem[bk];
  end

  always_ff @(posedge clk) begin
    if (qty_we) qty_mem[seg_s] <= acc_new;
    qty_q <= qty_mem[ei];
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      count        <= '0;
      result_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (start) count <= '0;
      else if (store) count <= count + CW'(1);
      if (result_load) result_valid <= 1'b1;
      else if (!result_stall) result_valid <= 1'b0;
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (start) begin
          k          <= '0;
          last_idx   <= full ? AW'(MAX_PERIODS - 1) : store_idx;
          setup_flag <= '0;
        end
      end
      ST_KLD: begin
        dem_k  <= dem_q;
        hold_k <= hold_q;
        j      <= '0;
      end
      ST_JCARRY: begin
        opnd     <= OPND_W'(unit_q) + OPND_W'(carry_new);
        lot_hold <= lot_q;
        bprev    <= (j == '0) ? '0 : best_q;
      end
      ST_JMUL:   prod <= dem_k * opnd;
      ST_JLOT:   lot_hold <= lot_new;
      ST_JCMP: begin
        // strict compare keeps the earliest setup on a tie
        if (j == '0 || cand < best_r) begin
          best_r <= cand;
          arg    <= j;
        end
        if (j != k) j <= j + AW'(1);
      end
      ST_KEND: begin
        if (k == last_idx) begin
          total <= best_r;
          bk    <= k;
        end else begin
          k <= k + AW'(1);
        end
      end
      ST_BSEL: begin
        seg_s               <= seg_sel;
        bj                  <= seg_sel;
        acc                 <= '0;
        setup_flag[seg_sel] <= 1'b1;
      end
      ST_DACC: begin
        if (bj == bk) begin
          if (seg_s != '0) bk <= seg_s - AW'(1);
          else ei <= '0;
        end else begin
          acc <= acc_new;
          bj  <= bj + AW'(1);
        end
      end
      ST_ELOAD: begin
        if (out_free && ei != last_idx) ei <= ei + AW'(1);
      end
      default: ;
    endcase

    if (result_load) begin
      result.period_index <= IDX_W'(ei);
      result.lot_quantity <= setup_flag[ei] ? qty_q : '0;
      result.total_cost   <= total;
      result.last_result  <= (ei == last_idx);
    end
  end

  `LSDP_ASSERT_IMP(a_cand_bound, state == ST_JCMP, j <= k, "candidate index past current period")
  `LSDP_ASSERT_IMP(a_seg_bound, state == ST_DACC, seg_s <= bj && bj <= bk, "lot sum outside segment")
  `LSDP_ASSERT_IMP(a_count_bound, state != ST_IDLE, count == '0, "period count not cleared on solve")
  `LSDP_ASSERT_NXT(a_solve_done, state == ST_KEND && k == last_idx, state == ST_BRD, "backtrack not started")
  `LSDP_ASSERT_NXT(a_result_src, !result_valid, !result_valid || $past(state) == ST_ELOAD, "stray result")

endmodule
